[design/lpwf_pkg.sv]
// ----------------------------------------------------------------------------
// Longest palindrome word finder package
// Shared widths, the command passed from front to back, the result layout
// and the back-end state type.
// ----------------------------------------------------------------------------
package lpwf_pkg;

    localparam int LEN_W          = 7;
    localparam int CNT_W          = 16;
    localparam int TOKEN_LIMIT_DEF = 99;
    localparam int Q_DEPTH        = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // One classified byte as seen by the back end.
    typedef struct packed {
        logic             keep;     // store ch at wr_addr
        logic [LEN_W-1:0] wr_addr;
        logic [7:0]       ch;       // folded byte
        logic             finish;   // token ends with this byte
        logic [LEN_W-1:0] len;      // kept length of the ending token
        logic             eot;      // summary follows
    } t_cmd;

    typedef struct packed {
        logic             is_palindrome;
        logic [LEN_W-1:0] word_length;
        logic [LEN_W-1:0] longest_length;
        logic [CNT_W-1:0] longest_ordinal;
        logic [CNT_W-1:0] palindrome_count;
        logic             text_done;
    } t_result;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WALK,
        B_RES,
        B_SUM
    } t_bstate;

endpackage

[design/lpwf_in_if.sv]
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel that carries one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
interface lpwf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

[design/lpwf_out_if.sv]
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel that carries one word or summary result.
// ----------------------------------------------------------------------------
interface lpwf_out_if;
    import lpwf_pkg::*;

    logic             valid;
    logic             ready;
    logic             is_palindrome;
    logic [LEN_W-1:0] word_length;
    logic [LEN_W-1:0] longest_length;
    logic [CNT_W-1:0] longest_ordinal;
    logic [CNT_W-1:0] palindrome_count;
    logic             text_done;

    modport source (output valid, output is_palindrome, output word_length,
                    output longest_length, output longest_ordinal,
                    output palindrome_count, output text_done, input ready);
    modport sink   (input valid, input is_palindrome, input word_length,
                    input longest_length, input longest_ordinal,
                    input palindrome_count, input text_done, output ready);
endinterface

[design/longest_palindrome_word_finder_core.sv]
// ----------------------------------------------------------------------------
// Longest palindrome word finder
// Reads text one byte at a time and reports, for every whitespace-separated
// token, whether its letters and digits read the same both ways.
// ----------------------------------------------------------------------------
// The classifier takes one byte per cycle into a four-entry queue. The
// checker takes each queued byte in turn, kept or dropped, and at the end
// of a token walks the word store from both ends, one pair per cycle. The
// result of the word is then registered, and an end-of-text summary follows
// it. The input stalls only while the queue is full, and the output register
// lets the next word be checked while a result waits to be taken.
module longest_palindrome_word_finder_core #(
    parameter int TOKEN_LIMIT = lpwf_pkg::TOKEN_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpwf_in_if.sink    i_byte,
    lpwf_out_if.source o_result
);
    import lpwf_pkg::*;

    logic push_valid;
    logic push_ready;
    t_cmd push_data;
    logic pop_valid;
    logic pop_ready;
    t_cmd pop_data;

    lpwf_front #(
        .TOKEN_LIMIT (TOKEN_LIMIT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    lpwf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    lpwf_back #(
        .TOKEN_LIMIT (TOKEN_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_result    (o_result)
    );

endmodule

[design/lpwf_front.sv]
// ----------------------------------------------------------------------------
// Byte classifier
// Splits the byte stream into tokens, folds and filters letters and digits,
// and turns every byte into a command for the back end.
// ----------------------------------------------------------------------------
module lpwf_front #(
    parameter int TOKEN_LIMIT = lpwf_pkg::TOKEN_LIMIT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lpwf_in_if.sink        i_byte,
    output logic           o_push_valid,
    output lpwf_pkg::t_cmd o_push_data,
    input  logic           i_push_ready
);
    import lpwf_pkg::*;

    logic [LEN_W-1:0] r_raw, n_raw;
    logic [LEN_W-1:0] r_kept, n_kept;
    logic [LEN_W:0]   raw_inc;
    logic             is_space;
    logic             is_alnum;
    logic             keep;
    logic             finish;
    logic [7:0]       folded;
    logic             accept;

    assign i_byte.ready = i_push_ready;
    assign accept       = i_byte.valid && i_push_ready;
    assign o_push_valid = i_byte.valid;

    always_comb begin
        is_space = i_byte.ch inside {8'h20, [8'h09:8'h0D]};
        is_alnum = i_byte.ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
        folded   = (i_byte.ch inside {[8'h41:8'h5A]}) ? i_byte.ch + 8'd32 : i_byte.ch;
        raw_inc  = {1'b0, r_raw} + {{LEN_W{1'b0}}, 1'b1};
        keep     = !is_space && is_alnum && (r_kept < LEN_W'(TOKEN_LIMIT));
        // A non-space byte always leaves an open token, so end of text closes it.
        if (is_space) begin
            finish = (r_raw != '0);
        end else begin
            finish = (raw_inc >= (LEN_W+1)'(TOKEN_LIMIT)) || i_byte.end_of_text;
        end

        o_push_data.keep    = keep;
        o_push_data.wr_addr = r_kept;
        o_push_data.ch      = folded;
        o_push_data.finish  = finish;
        o_push_data.len     = r_kept + LEN_W'(keep);
        o_push_data.eot     = i_byte.end_of_text;

        if (finish || i_byte.end_of_text) begin
            n_raw  = '0;
            n_kept = '0;
        end else if (is_space) begin
            n_raw  = r_raw;
            n_kept = r_kept;
        end else begin
            n_raw  = raw_inc[LEN_W-1:0];
            n_kept = r_kept + LEN_W'(keep);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw  <= '0;
            r_kept <= '0;
        end else if (accept) begin
            r_raw  <= n_raw;
            r_kept <= n_kept;
        end
    end

endmodule

[design/lpwf_queue.sv]
// ----------------------------------------------------------------------------
// Command queue
// Small first-in first-out buffer between the classifier and the back end.
// ----------------------------------------------------------------------------
module lpwf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  lpwf_pkg::t_cmd i_push_data,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output lpwf_pkg::t_cmd o_pop_data,
    input  logic           i_pop_ready
);
    import lpwf_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != (PTR_W+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

[design/lpwf_back.sv]
// ----------------------------------------------------------------------------
// Word checker
// Stores kept bytes, walks each finished word from both ends, keeps the
// longest palindrome and the count, and drives the result register.
// ----------------------------------------------------------------------------
module lpwf_back #(
    parameter int TOKEN_LIMIT = lpwf_pkg::TOKEN_LIMIT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    input  lpwf_pkg::t_cmd i_pop_data,
    output logic           o_pop_ready,
    lpwf_out_if.source     o_result
);
    import lpwf_pkg::*;

    localparam int ADDR_W = $clog2(TOKEN_LIMIT);

    logic [7:0]       r_store [TOKEN_LIMIT];
    logic [7:0]       r_rd_lo;
    logic [7:0]       r_rd_hi;

    t_bstate          r_state, n_state;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_lo;
    logic [LEN_W-1:0] r_hi;
    logic             r_pal;
    logic             r_rd_vld;
    logic             r_eot;
    logic [LEN_W-1:0] r_best_len;
    logic [CNT_W-1:0] r_best_ord;
    logic [CNT_W-1:0] r_count;
    t_result          r_out;
    logic             r_out_vld;

    logic             pop;
    logic             issue;
    logic             slot_free;
    logic             load_res;
    logic             load_sum;
    logic [CNT_W-1:0] n_count;
    logic [LEN_W-1:0] n_best_len;
    logic [CNT_W-1:0] n_best_ord;

    assign pop       = (r_state == B_IDLE) && i_pop_valid;
    assign issue     = (r_state == B_WALK) && (r_len != '0) && (r_lo < r_hi);
    assign slot_free = !r_out_vld || o_result.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (pop) begin
                    if (i_pop_data.finish) begin
                        n_state = B_WALK;
                    end else if (i_pop_data.eot) begin
                        n_state = B_SUM;
                    end
                end
            end
            B_WALK: begin
                if (!issue && !r_rd_vld) begin
                    n_state = B_RES;
                end
            end
            B_RES: begin
                if (slot_free) begin
                    n_state = r_eot ? B_SUM : B_IDLE;
                end
            end
            B_SUM: begin
                if (slot_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Outputs and running totals.
    always_comb begin
        o_pop_ready = (r_state == B_IDLE);
        load_res    = (r_state == B_RES) && slot_free;
        load_sum    = (r_state == B_SUM) && slot_free;
        n_count     = r_count;
        n_best_len  = r_best_len;
        n_best_ord  = r_best_ord;
        if (r_pal) begin
            n_count = (r_count == CNT_MAX) ? r_count : r_count + CNT_W'(1);
            if (r_len > r_best_len) begin
                n_best_len = r_len;
                n_best_ord = n_count;
            end
        end
    end

    // Kept bytes; each walk step reads one pair.
    always_ff @(posedge i_clk) begin
        if (pop && i_pop_data.keep) begin
            r_store[i_pop_data.wr_addr[ADDR_W-1:0]] <= i_pop_data.ch;
        end
        if (issue) begin
            r_rd_lo <= r_store[r_lo[ADDR_W-1:0]];
            r_rd_hi <= r_store[r_hi[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_rd_vld   <= 1'b0;
            r_best_len <= '0;
            r_best_ord <= '0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
            r_pal      <= 1'b0;
            r_eot      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                r_len    <= i_pop_data.len;
                r_lo     <= '0;
                r_hi     <= i_pop_data.len - LEN_W'(1);
                r_pal    <= (i_pop_data.len != '0);
                r_eot    <= i_pop_data.eot;
                r_rd_vld <= 1'b0;
            end else if (r_state == B_WALK) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_lo <= r_lo + LEN_W'(1);
                    r_hi <= r_hi - LEN_W'(1);
                end
                if (r_rd_vld && (r_rd_lo != r_rd_hi)) begin
                    r_pal <= 1'b0;
                end
            end

            if (load_res) begin
                r_count    <= n_count;
                r_best_len <= n_best_len;
                r_best_ord <= n_best_ord;
            end else if (load_sum) begin
                r_count    <= '0;
                r_best_len <= '0;
                r_best_ord <= '0;
            end

            if (load_res || load_sum) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_out.is_palindrome    <= r_pal;
            r_out.word_length      <= r_len;
            r_out.longest_length   <= n_best_len;
            r_out.longest_ordinal  <= n_best_ord;
            r_out.palindrome_count <= n_count;
            r_out.text_done        <= 1'b0;
        end else if (load_sum) begin
            r_out.is_palindrome    <= 1'b0;
            r_out.word_length      <= '0;
            r_out.longest_length   <= r_best_len;
            r_out.longest_ordinal  <= r_best_ord;
            r_out.palindrome_count <= r_count;
            r_out.text_done        <= 1'b1;
        end
    end

    assign o_result.valid            = r_out_vld;
    assign o_result.is_palindrome    = r_out.is_palindrome;
    assign o_result.word_length      = r_out.word_length;
    assign o_result.longest_length   = r_out.longest_length;
    assign o_result.longest_ordinal  = r_out.longest_ordinal;
    assign o_result.palindrome_count = r_out.palindrome_count;
    assign o_result.text_done        = r_out.text_done;

endmodule

[bench/longest_palindrome_word_finder_core_tb.sv]
// ----------------------------------------------------------------------------
// Longest palindrome word finder testbench
// Feeds text bytes through the input channel and checks each word and summary
// result against a predictor that follows the token, fold and count rules.
// Starts with directed words, one at the token limit, then runs random text
// with punctuation and long tokens, then two short words and a final summary.
// ----------------------------------------------------------------------------
module longest_palindrome_word_finder_core_tb;
    import lpwf_pkg::*;

    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_VT  = 8'h0b;
    localparam logic [7:0] CH_FF  = 8'h0c;
    localparam logic [7:0] CH_CR  = 8'h0d;

    localparam int IDLE_PCT     = 11;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 120;
    localparam int SHOW_LIMIT   = 40;

    // Tracks the token, the running longest palindrome and the count, and
    // keeps the results that the block still owes.
    class word_result_tracker;
        t_result          expected_results[$];
        logic [7:0]       letters[TOKEN_LIMIT_DEF];
        int               kept_len;
        int               raw_len;
        logic [LEN_W-1:0] best_len;
        logic [CNT_W-1:0] best_ord;
        logic [CNT_W-1:0] pal_count;
        int               errors;
        int               shown;

        function new();
            errors = 0;
            shown  = 0;
            clear_text();
        endfunction

        static function bit is_space(logic [7:0] c);
            return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
        endfunction

        static function bit is_alnum(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                   (c >= "A" && c <= "Z");
        endfunction

        function void clear_text();
            kept_len  = 0;
            raw_len   = 0;
            best_len  = '0;
            best_ord  = '0;
            pal_count = '0;
        endfunction

        function void push(bit pal, int len, bit done);
            t_result r;
            r.is_palindrome    = pal;
            r.word_length      = LEN_W'(len);
            r.longest_length   = best_len;
            r.longest_ordinal  = best_ord;
            r.palindrome_count = pal_count;
            r.text_done        = done;
            expected_results.push_back(r);
        endfunction

        function void close_word();
            bit pal;
            int i;
            pal = kept_len > 0;
            for (i = 0; i < kept_len / 2; i++) begin
                if (letters[i] != letters[kept_len - 1 - i]) pal = 0;
            end
            if (pal) begin
                if (pal_count != CNT_MAX) pal_count++;
                // Only a strictly longer palindrome takes over.
                if (kept_len > best_len) begin
                    best_len = LEN_W'(kept_len);
                    best_ord = pal_count;
                end
            end
            push(pal, kept_len, 1'b0);
            kept_len = 0;
            raw_len  = 0;
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            logic [7:0] k;
            k = c;
            if (is_space(c)) begin
                if (raw_len > 0) close_word();
            end else begin
                raw_len++;
                if (is_alnum(c) && kept_len < TOKEN_LIMIT_DEF) begin
                    if (c >= "A" && c <= "Z") k = c + 8'd32;
                    letters[kept_len] = k;
                    kept_len++;
                end
                if (raw_len >= TOKEN_LIMIT_DEF) close_word();
            end
            if (last) begin
                if (raw_len > 0) close_word();
                push(1'b0, 0, 1'b1);
                clear_text();
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got);
            if (want !== got) begin
                errors++;
                if (shown < SHOW_LIMIT)
                    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                shown++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                errors++;
                if (shown < SHOW_LIMIT)
                    $display("%0t: result %h arrived with none expected", $time, got);
                shown++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("is_palindrome", want.is_palindrome, got.is_palindrome);
            compare_field("word_length", want.word_length, got.word_length);
            compare_field("longest_length", want.longest_length, got.longest_length);
            compare_field("longest_ordinal", want.longest_ordinal, got.longest_ordinal);
            compare_field("palindrome_count", want.palindrome_count,
                          got.palindrome_count);
            compare_field("text_done", want.text_done, got.text_done);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   results_seen;

    lpwf_in_if  in_if();
    lpwf_out_if out_if();

    word_result_tracker tracker = new();

    longest_palindrome_word_finder_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (in_if),
        .o_result (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic bit idle_draw();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic logic [7:0] random_alnum();
        int r;
        r = $urandom_range(0, 35);
        return (r < 10) ? 8'(8'h30 + r) : 8'(8'h61 + r - 10);
    endfunction

    function automatic logic [7:0] random_dropped();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (word_result_tracker::is_alnum(c) || word_result_tracker::is_space(c));
        return c;
    endfunction

    function automatic logic [7:0] random_space();
        case ($urandom_range(0, 5))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // Valid stays high after an item so back-to-back items need no toggle.
    task automatic send_byte(input logic [7:0] c, input logic last);
        while (idle_draw()) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.ch          <= c;
        in_if.end_of_text <= last;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.note_byte(c, last);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_random_word(output int n_items);
        logic [7:0] w[$];
        logic [7:0] c;
        int         len;
        int         roll;
        int         i;
        bit         pal;
        bit         last;
        n_items = 0;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            // Raw noise, end-of-text included now and then.
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 49) == 0);
                n_items++;
            end
            return;
        end
        if ($urandom_range(0, 99) < 4) len = $urandom_range(90, 120);
        else if ($urandom_range(0, 99) < 12) len = $urandom_range(9, 40);
        else len = $urandom_range(1, 8);
        pal = roll < 65;
        for (i = 0; i < len; i++) begin
            if (pal && i >= (len + 1) / 2) w.push_back(w[len - 1 - i]);
            else w.push_back(random_alnum());
        end
        for (i = 0; i < w.size(); i++) begin
            if ($urandom_range(0, 99) < 8) begin
                send_byte(random_dropped(), 1'b0);
                n_items++;
            end
            c = w[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
            send_byte(c, 1'b0);
            n_items++;
        end
        len = ($urandom_range(0, 99) < 80) ? 1 : $urandom_range(2, 3);
        for (i = 0; i < len; i++) begin
            last = (i == len - 1) && ($urandom_range(0, 99) < 3);
            send_byte(random_space(), last);
            n_items++;
        end
    endtask

    initial begin : result_sink
        t_result got;
        int      hold_left;
        bit      held;
        hold_left    = 0;
        held         = 0;
        results_seen = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.is_palindrome    = out_if.is_palindrome;
                got.word_length      = out_if.word_length;
                got.longest_length   = out_if.longest_length;
                got.longest_ordinal  = out_if.longest_ordinal;
                got.palindrome_count = out_if.palindrome_count;
                got.text_done        = out_if.text_done;
                tracker.check_result(got);
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (!held && results_seen == HOLD_AT) begin
                // Long back-pressure so the byte queue fills and stalls input.
                held = 1;
                hold_left = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !idle_draw();
            end
        end
    end

    initial begin : byte_source
        int sent;
        int n;
        calm = 0;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.ch          <= 8'h00;
        in_if.end_of_text <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("Ab#Ba");
        send_byte(CH_TAB, 1'b0);
        send_text("dEEd");              // same length, must not take over
        send_byte(CH_LF, 1'b0);
        send_text("xy");
        send_byte(CH_VT, 1'b0);
        send_byte(8'h00, 1'b0);         // token of dropped bytes only
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(CH_FF, 1'b0);
        send_text("7");
        send_byte(CH_CR, 1'b0);
        send_byte(CH_SP, 1'b0);
        send_text("0Z9z0");
        send_byte(CH_SP, 1'b0);
        repeat (TOKEN_LIMIT_DEF) send_byte("a", 1'b0);
        send_byte("Q", 1'b1);           // open token flushed, then summary
        send_byte(CH_SP, 1'b1);         // summary alone

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = (sent > 600 && sent < 1000);
            send_random_word(n);
            sent += n;
        end
        calm = 0;

        // A short palindrome, a near miss, and a closing summary.
        send_text("aBa");
        send_byte(CH_LF, 1'b0);
        send_text("abca");
        send_byte(CH_SP, 1'b1);

        in_if.valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
